@@ sv/etc1_pkg.sv @@
package etc1_pkg;

  localparam int PixPerBlock = 16;
  localparam logic [3:0] LastPix = 4'(PixPerBlock - 1);

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // decoded block held while its sixteen pixels go out
  typedef struct packed {
    rgb_t        base1;
    rgb_t        base2;
    logic [2:0]  cwd1;
    logic [2:0]  cwd2;
    logic        flip;
    logic [31:0] index_word;
  } block_t;

  typedef struct packed {
    logic [1:0] pix_x;
    logic [1:0] pix_y;
    rgb_t       color;
    logic       last_pixel;
  } pix_t;

  // modifier magnitude: sel=0 gives the small one, sel=1 the large one
  function automatic logic [7:0] mod_mag(input logic [2:0] cwd, input logic sel);
    logic [7:0] a;
    logic [7:0] b;
    unique case (cwd)
      3'd0: begin a = 8'd2;  b = 8'd8;   end
      3'd1: begin a = 8'd5;  b = 8'd17;  end
      3'd2: begin a = 8'd9;  b = 8'd29;  end
      3'd3: begin a = 8'd13; b = 8'd42;  end
      3'd4: begin a = 8'd18; b = 8'd60;  end
      3'd5: begin a = 8'd24; b = 8'd80;  end
      3'd6: begin a = 8'd33; b = 8'd106; end
      default: begin a = 8'd47; b = 8'd183; end
    endcase
    return sel ? b : a;
  endfunction

  function automatic logic [7:0] add_clamp(input logic [7:0] base, input logic [7:0] mag,
                                           input logic neg);
    logic [9:0] sum;
    logic [7:0] res;
    sum = neg ? ({2'b00, base} - {2'b00, mag}) : ({2'b00, base} + {2'b00, mag});
    if (neg && sum[9]) begin
      res = 8'd0;
    end else if (!neg && sum[8]) begin
      res = 8'hff;
    end else begin
      res = sum[7:0];
    end
    return res;
  endfunction

endpackage

@@ sv/etc1_base_decode.sv @@
module etc1_base_decode (
  input  logic [31:0]          color_word,
  input  logic [31:0]          index_word,
  output etc1_pkg::block_t     blk
);

  logic [7:0] chan [3];
  logic [7:0] b1 [3];
  logic [7:0] b2 [3];
  logic [4:0] v5 [3];
  logic [4:0] s5 [3];
  logic       diff;

  assign diff = color_word[1];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      chan[c] = color_word[31 - 8*c -: 8];
      v5[c]   = chan[c][7:3];
      // 3-bit signed delta, sum wraps mod 32
      s5[c]   = v5[c] + {{2{chan[c][2]}}, chan[c][2:0]};
      if (diff) begin
        b1[c] = {v5[c], v5[c][4:2]};
        b2[c] = {s5[c], s5[c][4:2]};
      end else begin
        b1[c] = {chan[c][7:4], chan[c][7:4]};
        b2[c] = {chan[c][3:0], chan[c][3:0]};
      end
    end
  end

  assign blk.base1      = '{red: b1[0], green: b1[1], blue: b1[2]};
  assign blk.base2      = '{red: b2[0], green: b2[1], blue: b2[2]};
  assign blk.cwd1       = color_word[7:5];
  assign blk.cwd2       = color_word[4:2];
  assign blk.flip       = color_word[0];
  assign blk.index_word = index_word;

endmodule

@@ sv/etc1_pixel.sv @@
module etc1_pixel (
  input  etc1_pkg::block_t blk,
  input  logic [3:0]       cnt,
  output etc1_pkg::pix_t   pix
);

  logic [1:0]     px;
  logic [1:0]     py;
  logic [3:0]     pos;
  logic           sb;
  logic [1:0]     idx;
  logic [7:0]     mag;
  etc1_pkg::rgb_t base;

  assign py  = cnt[3:2];
  assign px  = cnt[1:0];
  // index bits are stored column-major
  assign pos = {px, py};
  assign sb  = blk.flip ? py[1] : px[1];
  // high index bit sits 16 above the low one
  assign idx = {blk.index_word[{1'b1, pos}], blk.index_word[{1'b0, pos}]};

  assign base = sb ? blk.base2 : blk.base1;
  assign mag  = etc1_pkg::mod_mag(sb ? blk.cwd2 : blk.cwd1, idx[0]);

  assign pix.pix_x       = px;
  assign pix.pix_y       = py;
  assign pix.color.red   = etc1_pkg::add_clamp(base.red, mag, idx[1]);
  assign pix.color.green = etc1_pkg::add_clamp(base.green, mag, idx[1]);
  assign pix.color.blue  = etc1_pkg::add_clamp(base.blue, mag, idx[1]);
  assign pix.last_pixel  = (cnt == etc1_pkg::LastPix);

endmodule

@@ sv/etc1_block_decoder.sv @@
// channel | dir | tdata (low bit up)                               | tlast
// s_axis  | in  | color_word[31:0], index_word[63:32]              | -
// m_axis  | out | pix_x[1:0], pix_y[3:2], red[11:4], green[19:12], | last_pixel
//         |     | blue[27:20], zero[31:28]                         |
// One block request yields 16 pixel requests, one per cycle while the output is not
// stalled, drained from the block register through the single output register.
// Pixel 0 passes through the block register and then the pixel register to m_axis.
// The next block is taken in the cycle its predecessor's last pixel moves into the pixel register.
// Output stalls hold the pixel register; the block register waits behind it.
// rst is synchronous, active high, and empties both registers.
module etc1_block_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // color_word, index_word
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // pix_x, pix_y, red, green, blue, pad
  output logic        m_axis_tlast
);

  etc1_pkg::block_t blk_dec;
  etc1_pkg::block_t blk;
  etc1_pkg::pix_t   pix_next;
  etc1_pkg::pix_t   pix;
  logic             blk_v;
  logic             out_v;
  logic [3:0]       cnt;
  logic             adv;
  logic             blk_done;
  logic             s_acc;

  etc1_base_decode u_dec (
    .color_word (s_axis_tdata[31:0]),
    .index_word (s_axis_tdata[63:32]),
    .blk        (blk_dec)
  );

  etc1_pixel u_pix (
    .blk (blk),
    .cnt (cnt),
    .pix (pix_next)
  );

  assign adv           = blk_v && (!out_v || m_axis_tready);
  assign blk_done      = adv && (cnt == etc1_pkg::LastPix);
  assign s_axis_tready = !blk_v || blk_done;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      blk_v <= 1'b0;
      out_v <= 1'b0;
      cnt   <= '0;
    end else begin
      if (s_acc) begin
        blk_v <= 1'b1;
      end else if (blk_done) begin
        blk_v <= 1'b0;
      end
      if (adv) begin
        cnt   <= cnt + 4'd1;
        out_v <= 1'b1;
      end else if (m_axis_tready) begin
        out_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      blk <= blk_dec;
    end
    if (adv) begin
      pix <= pix_next;
    end
  end

  assign m_axis_tvalid = out_v;
  assign m_axis_tlast  = pix.last_pixel;
  assign m_axis_tdata  = {4'h0, pix.color.blue, pix.color.green, pix.color.red,
                          pix.pix_y, pix.pix_x};

`ifndef NO_ASSERTIONS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (s_acc && blk_v) |-> blk_done)
    else $error("block register overwritten before its last pixel");

  a_cnt_idle: assert property (@(posedge clk) disable iff (rst)
    !blk_v |-> (cnt == 4'd0))
    else $error("pixel counter not at zero while no block is held");

  a_accept_start: assert property (@(posedge clk) disable iff (rst)
    s_acc |=> (blk_v && cnt == 4'd0))
    else $error("accepted block does not start at pixel zero");

  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    (out_v && pix.last_pixel) |-> (pix.pix_x == 2'd3 && pix.pix_y == 2'd3))
    else $error("last pixel flag away from the corner pixel");
`endif

endmodule

@@ verif/tb_etc1_block_decoder.sv @@
module tb_etc1_block_decoder;

  typedef struct {
    logic [1:0] x;
    logic [1:0] y;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } pixel_t;

  typedef struct {
    logic [31:0] color_word;
    logic [31:0] index_word;
    int          gap;
    bit          drain;
  } block_req_t;

  localparam int MagSmall [8] = '{2, 5, 9, 13, 18, 24, 33, 47};
  localparam int MagLarge [8] = '{8, 17, 29, 42, 60, 80, 106, 183};
  localparam int LongHoldPixel = 1600;
  localparam int LongHoldCycles = 400;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;

  block_req_t pending_blocks[$];
  pixel_t     expected_pixels[$];
  block_req_t cur_block;
  bit         block_loaded = 1'b0;
  bit         offering = 1'b0;
  int         blocks_taken = 0;
  int         pixels_seen = 0;
  int         out_wait = 0;
  int         errors = 0;

  etc1_block_decoder u_top (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // push the sixteen pixels of one compressed block, raster order
  function automatic void decode_block(input logic [31:0] cw, input logic [31:0] iw);
    logic [7:0] base [2][3];
    logic [7:0] chan;
    logic [4:0] b5;
    logic [4:0] b5_sum;
    logic [2:0] cwd;
    logic [3:0] pos;
    logic [7:0] rgb [3];
    int         sb;
    int         m;
    int         sum;
    pixel_t     p;
    for (int c = 0; c < 3; c++) begin
      chan = cw[31 - 8 * c -: 8];
      if (cw[1]) begin
        b5 = chan[7:3];
        // 3-bit signed delta, wraps mod 32
        b5_sum = b5 + {{2{chan[2]}}, chan[2:0]};
        base[0][c] = {b5, b5[4:2]};
        base[1][c] = {b5_sum, b5_sum[4:2]};
      end else begin
        base[0][c] = {chan[7:4], chan[7:4]};
        base[1][c] = {chan[3:0], chan[3:0]};
      end
    end
    for (int y = 0; y < 4; y++) begin
      for (int x = 0; x < 4; x++) begin
        pos = 4'(x * 4 + y);
        sb = cw[0] ? y / 2 : x / 2;
        cwd = (sb == 0) ? cw[7:5] : cw[4:2];
        m = iw[pos] ? MagLarge[cwd] : MagSmall[cwd];
        if (iw[16 + pos]) m = -m;
        for (int c = 0; c < 3; c++) begin
          sum = int'(base[sb][c]) + m;
          rgb[c] = (sum < 0) ? 8'd0 : (sum > 255) ? 8'd255 : 8'(sum);
        end
        p.x = 2'(x);
        p.y = 2'(y);
        p.red = rgb[0];
        p.green = rgb[1];
        p.blue = rgb[2];
        p.last = (x == 3 && y == 3);
        expected_pixels.push_back(p);
      end
    end
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  function automatic void add_block(input logic [31:0] cw, input logic [31:0] iw,
                                    input int gap, input bit drain);
    block_req_t b;
    b.color_word = cw;
    b.index_word = iw;
    b.gap = gap;
    b.drain = drain;
    pending_blocks.push_back(b);
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      offering = 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        decode_block(s_axis_tdata[31:0], s_axis_tdata[63:32]);
        blocks_taken++;
        offering = 1'b0;
      end
      if (!offering) begin
        if (!block_loaded && pending_blocks.size() > 0) begin
          cur_block = pending_blocks.pop_front();
          block_loaded = 1'b1;
        end
        if (block_loaded) begin
          if (cur_block.drain && expected_pixels.size() != 0) begin
            // hold until the decoder has fully drained
          end else if (cur_block.gap > 0) begin
            cur_block.gap--;
          end else begin
            s_axis_tdata <= {cur_block.index_word, cur_block.color_word};
            offering = 1'b1;
            block_loaded = 1'b0;
          end
        end
      end
      s_axis_tvalid <= offering;
    end
  end

  // pixel monitor and receiver backpressure
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      out_wait = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_pixels.size() == 0) begin
          $error("unexpected pixel: tdata %h tlast %b", m_axis_tdata, m_axis_tlast);
          errors++;
        end else begin
          pixel_t want;
          want = expected_pixels.pop_front();
          check_field("pix_x", want.x, m_axis_tdata[1:0]);
          check_field("pix_y", want.y, m_axis_tdata[3:2]);
          check_field("red", want.red, m_axis_tdata[11:4]);
          check_field("green", want.green, m_axis_tdata[19:12]);
          check_field("blue", want.blue, m_axis_tdata[27:20]);
          check_field("last_pixel", want.last, m_axis_tlast);
        end
        pixels_seen++;
        case ((pixels_seen / 192) % 3)
          0:       out_wait = 0;
          1:       out_wait = $urandom_range(0, 19);
          default: out_wait = $urandom_range(0, 3);
        endcase
        if (pixels_seen == LongHoldPixel) out_wait = LongHoldCycles;
      end
      if (out_wait > 0) begin
        m_axis_tready <= 1'b0;
        out_wait--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    int total;
    int gap;
    logic [31:0] cw;
    // corners: all zero, all ones, clamp at both ends
    add_block(32'h0000_0000, 32'h0000_0000, 0, 1'b0);
    add_block(32'hffff_ffff, 32'hffff_ffff, 0, 1'b0);
    add_block(32'hf0f0_f0e0, 32'hffff_0000, 3, 1'b0);
    add_block(32'hf0f0_f0fc, 32'h0000_ffff, 0, 1'b0);
    add_block(32'h0f0f_0ffd, 32'hffff_ffff, 5, 1'b0);
    // differential wrap upward and downward
    add_block(32'hfbfb_fb02, 32'h5555_aaaa, 0, 1'b0);
    add_block(32'h0404_0403, 32'haaaa_5555, 0, 1'b0);
    add_block(32'h8383_8342, 32'h1234_5678, 2, 1'b0);
    // every codeword on both subblocks, both modes and flips
    for (int k = 0; k < 8; k++) begin
      cw = $urandom();
      cw[7:5] = 3'(k);
      cw[4:2] = 3'(7 - k);
      cw[1] = k[0];
      cw[0] = k[1];
      add_block(cw, $urandom(), $urandom_range(0, 4), 1'b0);
    end
    add_block(32'h8888_88f3, 32'h00ff_ff00, 0, 1'b0);
    add_block(32'h7777_771d, 32'hff00_00ff, 0, 1'b0);

    for (int n = 0; n < 340; n++) begin
      cw = $urandom();
      case ($urandom_range(0, 9))
        0: cw[31:8] = 24'hffffff;
        1: cw[31:8] = 24'h000000;
        2: cw[7:2] = 6'h3f;
        default: ;
      endcase
      if ((n / 20) % 3 == 0 || (n >= 85 && n < 130)) begin
        gap = 0;
      end else begin
        gap = $urandom_range(0, 19);
      end
      add_block(cw, $urandom(), gap, n == 60 || n == 250);
    end
    total = pending_blocks.size();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (blocks_taken < total) @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2500000;
    $display("Verification failed");
    $finish;
  end

endmodule
